// File: hw/rtl/teq_pkg.sv
package teq_pkg;

	// Default sizes
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int TIME_BITS_DEF   = 48;
	localparam int JOB_BITS_DEF    = 8;

	// Fixed field widths
	localparam int KIND_BITS   = 4;
	localparam int FUNC_BITS   = 3;
	localparam int STATUS_BITS = 2;
	localparam int CFG_IDX_BITS = 1;

	// Command codes
	localparam logic [FUNC_BITS-1:0] FN_INIT    = 3'd0;
	localparam logic [FUNC_BITS-1:0] FN_PEEK    = 3'd1;
	localparam logic [FUNC_BITS-1:0] FN_ADVANCE = 3'd2;
	localparam logic [FUNC_BITS-1:0] FN_INSERT  = 3'd3;
	localparam logic [FUNC_BITS-1:0] FN_DELAY   = 3'd4;
	localparam logic [FUNC_BITS-1:0] FN_CANCEL  = 3'd5;
	localparam logic [FUNC_BITS-1:0] FN_FIND    = 3'd6;
	localparam logic [FUNC_BITS-1:0] FN_CLEAR   = 3'd7;

	// Result status codes
	localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_MISS  = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_EARLY = 2'd2;
	localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd3;

	// Event kinds loaded by init
	localparam logic [KIND_BITS-1:0] KIND_BEGIN = 4'd0;
	localparam logic [KIND_BITS-1:0] KIND_END   = 4'd1;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_TIME = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_END_TIME   = 1'b1;

	// Cell operations
	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_REMOVE = 2'd2;
	localparam logic [1:0] CELL_LOAD   = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic       sel;   // remove: take right neighbor; load: take key
	} cell_ctl_t;

endpackage

// File: hw/rtl/teq_cell.sv
module teq_cell #(
	parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
	parameter int JOB_BITS  = teq_pkg::JOB_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  teq_pkg::cell_ctl_t             ctl,
	input  logic [TIME_BITS-1:0]           key_time,
	input  logic [teq_pkg::KIND_BITS-1:0]  key_kind,
	input  logic [JOB_BITS-1:0]            key_job,
	input  logic                           left_valid,
	input  logic [TIME_BITS-1:0]           left_time,
	input  logic [teq_pkg::KIND_BITS-1:0]  left_kind,
	input  logic [JOB_BITS-1:0]            left_job,
	input  logic                           left_place,
	input  logic                           right_valid,
	input  logic [TIME_BITS-1:0]           right_time,
	input  logic [teq_pkg::KIND_BITS-1:0]  right_kind,
	input  logic [JOB_BITS-1:0]            right_job,
	output logic                           valid,
	output logic [TIME_BITS-1:0]           ent_time,
	output logic [teq_pkg::KIND_BITS-1:0]  ent_kind,
	output logic [JOB_BITS-1:0]            ent_job,
	output logic                           place,
	output logic                           match
);
	import teq_pkg::*;

	logic                 valid_q, valid_d;
	logic [TIME_BITS-1:0] time_q, time_d;
	logic [KIND_BITS-1:0] kind_q, kind_d;
	logic [JOB_BITS-1:0]  job_q, job_d;

	// New key belongs here or earlier when this slot is empty or later than the key
	assign place = !valid_q || (time_q > key_time);
	assign match = valid_q && (kind_q == key_kind) && (job_q == key_job);

	always_comb begin
		valid_d = valid_q;
		time_d  = time_q;
		kind_d  = kind_q;
		job_d   = job_q;
		case (ctl.op)
			CELL_INSERT: begin
				if (place) begin
					if (left_place) begin
						valid_d = left_valid;
						time_d  = left_time;
						kind_d  = left_kind;
						job_d   = left_job;
					end else begin
						valid_d = 1'b1;
						time_d  = key_time;
						kind_d  = key_kind;
						job_d   = key_job;
					end
				end
			end
			CELL_REMOVE: begin
				if (ctl.sel) begin
					valid_d = right_valid;
					time_d  = right_time;
					kind_d  = right_kind;
					job_d   = right_job;
				end
			end
			CELL_LOAD: begin
				valid_d = ctl.sel;
				time_d  = key_time;
				kind_d  = key_kind;
				job_d   = key_job;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		time_q <= time_d;
		kind_q <= kind_d;
		job_q  <= job_d;
	end

	assign valid    = valid_q;
	assign ent_time = time_q;
	assign ent_kind = kind_q;
	assign ent_job  = job_q;

endmodule

// File: hw/rtl/timed_event_queue_core.sv
// Flow: an accepted item goes through the cell chain in ST_IDLE, init and delay make a second
//   pass in ST_REINS, and the result register is loaded in ST_RESULT once the output is free.
// Handshake: one item at a time; s_tready is high only in ST_IDLE, so no new item is taken
//   until the last result is loaded; the cell chain does one insert or remove per cycle.
// Reset: arst_n clears every cell's valid bit (queue empty), both time registers and
//   the output valid; cell payloads are not reset.
module timed_event_queue_core #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = teq_pkg::TIME_BITS_DEF,
	parameter int JOB_BITS    = teq_pkg::JOB_BITS_DEF,
	localparam int IN_BITS    = 2 * TIME_BITS + teq_pkg::KIND_BITS + JOB_BITS,
	localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS   = teq_pkg::STATUS_BITS + 1 + 2 * TIME_BITS
	                            + teq_pkg::KIND_BITS + JOB_BITS,
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave side
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// event_time, event_kind, job_tag, delay_amount (from bit 0 up)
	input  logic [IN_W-1:0]                   s_tdata,
	// func
	input  logic [teq_pkg::FUNC_BITS-1:0]     s_tuser,
	// master side
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status, head_valid, head_time, head_kind, head_job, found_time (from bit 0 up)
	output logic [OUT_W-1:0]                  m_tdata,
	// configuration
	input  logic                              cfg_we,
	input  logic [teq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [TIME_BITS-1:0]              cfg_wdata
);
	import teq_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_REINS  = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;

	// Input field offsets
	localparam int I_KIND  = TIME_BITS;
	localparam int I_JOB   = I_KIND + KIND_BITS;
	localparam int I_DELAY = I_JOB + JOB_BITS;

	logic [1:0] state_q, state_d;

	logic [TIME_BITS-1:0] start_time_q, end_time_q;

	// Unpacked input item
	logic [FUNC_BITS-1:0] in_func;
	logic [TIME_BITS-1:0] in_time;
	logic [KIND_BITS-1:0] in_kind;
	logic [JOB_BITS-1:0]  in_job;
	logic [TIME_BITS-1:0] in_delay;

	assign in_func  = s_tuser;
	assign in_time  = s_tdata[TIME_BITS-1:0];
	assign in_kind  = s_tdata[I_JOB-1:I_KIND];
	assign in_job   = s_tdata[I_DELAY-1:I_JOB];
	assign in_delay = s_tdata[I_DELAY+TIME_BITS-1:I_DELAY];

	// Cell chain taps
	logic [QUEUE_DEPTH-1:0] cv, cplace, cmatch;
	logic [TIME_BITS-1:0]   ct [QUEUE_DEPTH];
	logic [KIND_BITS-1:0]   ck [QUEUE_DEPTH];
	logic [JOB_BITS-1:0]    cj [QUEUE_DEPTH];
	cell_ctl_t              ctl [QUEUE_DEPTH];

	logic [1:0]             cell_op;
	logic [QUEUE_DEPTH-1:0] sel_vec;
	logic [TIME_BITS-1:0]   key_time;
	logic [KIND_BITS-1:0]   key_kind;
	logic [JOB_BITS-1:0]    key_job;

	// Pending reinsertion (second half of delay, end event of init)
	logic [TIME_BITS-1:0] rein_time_q, rein_time_d;
	logic [KIND_BITS-1:0] rein_kind_q, rein_kind_d;
	logic [JOB_BITS-1:0]  rein_job_q, rein_job_d;

	logic [STATUS_BITS-1:0] status_q, status_d;
	logic [TIME_BITS-1:0]   found_q, found_d;
	logic                   capture;

	logic                   out_valid_q;
	logic [OUT_BITS-1:0]    out_q;
	logic                   load_out;

	// Match search: first match from the head, and everything from it to the tail
	logic [QUEUE_DEPTH-1:0] first_hit, from_hit;
	logic [TIME_BITS-1:0]   hit_time;
	logic [TIME_BITS:0]     wide_sum;
	logic [TIME_BITS-1:0]   sat_sum;
	logic                   any_hit;
	logic                   q_empty, q_full;

	assign q_empty   = !cv[0];
	assign q_full    = cv[QUEUE_DEPTH-1];
	assign first_hit = cmatch & (~cmatch + QUEUE_DEPTH'(1));
	assign from_hit  = ~first_hit + QUEUE_DEPTH'(1);
	assign any_hit   = |cmatch;

	always_comb begin
		hit_time = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (first_hit[i]) begin
				hit_time = hit_time | ct[i];
			end
		end
	end

	// Saturate the delayed time at all ones
	assign wide_sum = {1'b0, hit_time} + {1'b0, in_delay};
	assign sat_sum  = wide_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : wide_sum[TIME_BITS-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_RESULT) && (!out_valid_q || m_tready);

	// Command sequencer
	always_comb begin
		state_d     = state_q;
		cell_op     = CELL_HOLD;
		sel_vec     = '0;
		key_time    = in_time;
		key_kind    = in_kind;
		key_job     = in_job;
		rein_time_d = rein_time_q;
		rein_kind_d = rein_kind_q;
		rein_job_d  = rein_job_q;
		status_d    = STAT_OK;
		found_d     = '0;
		capture     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					capture = 1'b1;
					state_d = ST_RESULT;
					unique case (in_func)
						FN_INIT: begin
							// Clear and seat the begin event at the head, then insert the end event
							cell_op     = CELL_LOAD;
							sel_vec[0]  = 1'b1;
							key_time    = start_time_q;
							key_kind    = KIND_BEGIN;
							key_job     = '0;
							rein_time_d = end_time_q;
							rein_kind_d = KIND_END;
							rein_job_d  = '0;
							state_d     = ST_REINS;
						end
						FN_PEEK: begin
							if (q_empty) status_d = STAT_MISS;
						end
						FN_ADVANCE: begin
							if (q_empty) begin
								status_d = STAT_MISS;
							end else begin
								cell_op = CELL_REMOVE;
								sel_vec = '1;
							end
						end
						FN_INSERT: begin
							if (!q_empty && (in_time < ct[0])) begin
								status_d = STAT_EARLY;
							end else if (q_full) begin
								status_d = STAT_FULL;
							end else begin
								cell_op = CELL_INSERT;
							end
						end
						FN_DELAY: begin
							if (!any_hit) begin
								status_d = STAT_MISS;
							end else begin
								// Pull the entry out now, put it back at its new time next cycle
								cell_op     = CELL_REMOVE;
								sel_vec     = from_hit;
								rein_time_d = sat_sum;
								rein_kind_d = in_kind;
								rein_job_d  = in_job;
								found_d     = sat_sum;
								state_d     = ST_REINS;
							end
						end
						FN_CANCEL: begin
							if (!any_hit) begin
								status_d = STAT_MISS;
							end else begin
								cell_op = CELL_REMOVE;
								sel_vec = from_hit;
							end
						end
						FN_FIND: begin
							if (!any_hit) begin
								status_d = STAT_MISS;
							end else begin
								found_d = hit_time;
							end
						end
						FN_CLEAR: begin
							cell_op = CELL_LOAD;
						end
						default: ;
					endcase
				end
			end
			ST_REINS: begin
				cell_op  = CELL_INSERT;
				key_time = rein_time_q;
				key_kind = rein_kind_q;
				key_job  = rein_job_q;
				state_d  = ST_RESULT;
			end
			ST_RESULT: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ctl[i].op  = cell_op;
			ctl[i].sel = sel_vec[i];
		end
	end

	// Chain of cells, head at index 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                 l_valid, l_place, r_valid;
		logic [TIME_BITS-1:0] l_time, r_time;
		logic [KIND_BITS-1:0] l_kind, r_kind;
		logic [JOB_BITS-1:0]  l_job, r_job;

		if (i == 0) begin : g_head
			assign l_valid = 1'b0;
			assign l_place = 1'b0;
			assign l_time  = '0;
			assign l_kind  = '0;
			assign l_job   = '0;
		end else begin : g_mid
			assign l_valid = cv[i-1];
			assign l_place = cplace[i-1];
			assign l_time  = ct[i-1];
			assign l_kind  = ck[i-1];
			assign l_job   = cj[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_time  = '0;
			assign r_kind  = '0;
			assign r_job   = '0;
		end else begin : g_body
			assign r_valid = cv[i+1];
			assign r_time  = ct[i+1];
			assign r_kind  = ck[i+1];
			assign r_job   = cj[i+1];
		end

		teq_cell #(
			.TIME_BITS (TIME_BITS),
			.JOB_BITS  (JOB_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl[i]),
			.key_time    (key_time),
			.key_kind    (key_kind),
			.key_job     (key_job),
			.left_valid  (l_valid),
			.left_time   (l_time),
			.left_kind   (l_kind),
			.left_job    (l_job),
			.left_place  (l_place),
			.right_valid (r_valid),
			.right_time  (r_time),
			.right_kind  (r_kind),
			.right_job   (r_job),
			.valid       (cv[i]),
			.ent_time    (ct[i]),
			.ent_kind    (ck[i]),
			.ent_job     (cj[i]),
			.place       (cplace[i]),
			.match       (cmatch[i])
		);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			start_time_q <= '0;
			end_time_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we && (cfg_index == CFG_START_TIME)) start_time_q <= cfg_wdata;
			if (cfg_we && (cfg_index == CFG_END_TIME)) end_time_q <= cfg_wdata;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rein_time_q <= rein_time_d;
		rein_kind_q <= rein_kind_d;
		rein_job_q  <= rein_job_d;
		if (capture) begin
			status_q <= status_d;
			found_q  <= found_d;
		end
		// Head is read after the chain has settled; empty queue shows zeros
		if (load_out) begin
			out_q <= {found_q,
			          cv[0] ? cj[0] : {JOB_BITS{1'b0}},
			          cv[0] ? ck[0] : {KIND_BITS{1'b0}},
			          cv[0] ? ct[0] : {TIME_BITS{1'b0}},
			          cv[0],
			          status_q};
		end
	end

	assign m_tvalid = out_valid_q;

	always_comb begin
		m_tdata                = '0;
		m_tdata[OUT_BITS-1:0]  = out_q;
	end

endmodule

// File: hw/rtl/teq_checker.sv
module teq_checker #(
	parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
	parameter int JOB_BITS  = teq_pkg::JOB_BITS_DEF,
	localparam int OUT_BITS = teq_pkg::STATUS_BITS + 1 + 2 * TIME_BITS
	                          + teq_pkg::KIND_BITS + JOB_BITS,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);
	import teq_pkg::*;

	localparam int O_VALID = STATUS_BITS;
	localparam int O_HEAD  = O_VALID + 1;
	localparam int O_FOUND = O_HEAD + TIME_BITS + KIND_BITS + JOB_BITS;

	// One item in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is still in progress");

	// A fresh result only follows a cycle in which the block was busy
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without work in progress");

	// Empty queue shows a zero head
	a_empty_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[O_VALID] |-> (m_tdata[O_FOUND-1:O_HEAD] == '0))
		else $error("head fields nonzero on empty queue");

	// Rejecting an early insert needs a head to compare against
	a_early_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[STATUS_BITS-1:0] == STAT_EARLY) |-> m_tdata[O_VALID])
		else $error("earlier-than-head status with empty queue");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind timed_event_queue_core teq_checker #(
	.TIME_BITS (TIME_BITS),
	.JOB_BITS  (JOB_BITS)
) u_teq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: test/timed_event_queue_core_tb.sv
`timescale 1ns / 100ps
module timed_event_queue_core_tb;
	import teq_pkg::*;

	localparam int          QD    = QUEUE_DEPTH_DEF;
	localparam logic [47:0] T_MAX = '1;

	// One result item as it sits in m_tdata; the last member lands in the lowest bits.
	typedef struct packed {
		logic [47:0]            found;
		logic [7:0]             job;
		logic [KIND_BITS-1:0]   kind;
		logic [47:0]            htime;
		logic                   hvalid;
		logic [STATUS_BITS-1:0] status;
	} head_view_t;

	// One row of the directed table; typed rows carry their own expected result
	typedef struct {
		logic [FUNC_BITS-1:0] func;
		logic [47:0]          t;
		logic [KIND_BITS-1:0] kind;
		logic [7:0]           job;
		logic [47:0]          dly;
		bit                   typed;
		head_view_t           want;
	} cmd_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	// event_time, event_kind, job_tag, delay_amount (from bit 0 up)
	logic [111:0]            s_tdata;
	// func
	logic [FUNC_BITS-1:0]    s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	// status, head_valid, head_time, head_kind, head_job, found_time (from bit 0 up)
	logic [111:0]            m_tdata;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [47:0]             cfg_wdata;

	timed_event_queue_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Shadow of the queue, kept sorted from the head, plus the two init times
	logic [47:0]          sq_time [QD];
	logic [KIND_BITS-1:0] sq_kind [QD];
	logic [7:0]           sq_job  [QD];
	int                   sq_count;
	logic [47:0]          cfg_start;
	logic [47:0]          cfg_end;

	head_view_t pending_views[$];
	cmd_row_t   dir_rows[$];
	int         errors;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         hold_cycles;

	// Drop entry i and close the gap
	function automatic void sq_drop(int i);
		for (int k = i; k + 1 < sq_count; k++) begin
			sq_time[k] = sq_time[k + 1];
			sq_kind[k] = sq_kind[k + 1];
			sq_job[k]  = sq_job[k + 1];
		end
		sq_count--;
	endfunction

	// Place a new entry behind every entry with a time less than or equal to it
	function automatic void sq_place(logic [47:0] t, logic [KIND_BITS-1:0] k, logic [7:0] j);
		int p;
		p = 0;
		if (sq_count >= QD)
			return;
		while (p < sq_count && sq_time[p] <= t)
			p++;
		for (int n = sq_count; n > p; n--) begin
			sq_time[n] = sq_time[n - 1];
			sq_kind[n] = sq_kind[n - 1];
			sq_job[n]  = sq_job[n - 1];
		end
		sq_time[p] = t;
		sq_kind[p] = k;
		sq_job[p]  = j;
		sq_count++;
	endfunction

	// First entry from the head whose kind and job both match, or -1
	function automatic int sq_lookup(logic [KIND_BITS-1:0] k, logic [7:0] j);
		for (int i = 0; i < sq_count; i++)
			if (sq_kind[i] == k && sq_job[i] == j)
				return i;
		return -1;
	endfunction

	// Apply one command to the shadow queue and return the head view it leaves
	function automatic head_view_t predict_head(logic [FUNC_BITS-1:0] f, logic [47:0] t,
			logic [KIND_BITS-1:0] k, logic [7:0] j, logic [47:0] d);
		head_view_t r;
		int         idx;
		logic [48:0] sum;
		r = '0;
		r.status = STAT_OK;
		case (f)
			FN_INIT: begin
				sq_count = 0;
				sq_place(cfg_start, KIND_BEGIN, 8'd0);
				sq_place(cfg_end, KIND_END, 8'd0);
			end
			FN_PEEK: begin
				if (sq_count == 0)
					r.status = STAT_MISS;
			end
			FN_ADVANCE: begin
				if (sq_count == 0)
					r.status = STAT_MISS;
				else
					sq_drop(0);
			end
			FN_INSERT: begin
				// earlier-than-head wins over full
				if (sq_count > 0 && t < sq_time[0])
					r.status = STAT_EARLY;
				else if (sq_count >= QD)
					r.status = STAT_FULL;
				else
					sq_place(t, k, j);
			end
			FN_DELAY: begin
				idx = sq_lookup(k, j);
				if (idx < 0) begin
					r.status = STAT_MISS;
				end else begin
					// saturate at the all-ones time
					sum = {1'b0, sq_time[idx]} + {1'b0, d};
					if (sum[48])
						sum[47:0] = T_MAX;
					sq_drop(idx);
					sq_place(sum[47:0], k, j);
					r.found = sum[47:0];
				end
			end
			FN_CANCEL: begin
				idx = sq_lookup(k, j);
				if (idx < 0)
					r.status = STAT_MISS;
				else
					sq_drop(idx);
			end
			FN_FIND: begin
				idx = sq_lookup(k, j);
				if (idx < 0)
					r.status = STAT_MISS;
				else
					r.found = sq_time[idx];
			end
			FN_CLEAR: begin
				sq_count = 0;
			end
		endcase
		if (sq_count > 0) begin
			r.hvalid = 1'b1;
			r.htime  = sq_time[0];
			r.kind   = sq_kind[0];
			r.job    = sq_job[0];
		end
		return r;
	endfunction

	function automatic head_view_t mk_view(logic [STATUS_BITS-1:0] st, logic hv,
			logic [47:0] ht, logic [KIND_BITS-1:0] hk, logic [7:0] hj, logic [47:0] fd);
		head_view_t r;
		r.status = st;
		r.hvalid = hv;
		r.htime  = ht;
		r.kind   = hk;
		r.job    = hj;
		r.found  = fd;
		return r;
	endfunction

	function automatic void add_row(logic [FUNC_BITS-1:0] f, logic [47:0] t,
			logic [KIND_BITS-1:0] k, logic [7:0] j, logic [47:0] d, bit typed, head_view_t w);
		cmd_row_t row;
		row.func  = f;
		row.t     = t;
		row.kind  = k;
		row.job   = j;
		row.dly   = d;
		row.typed = typed;
		row.want  = w;
		dir_rows = {dir_rows, row};
	endfunction

	function automatic logic [47:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	// Mostly at or just past the head, so inserts get in and equal times pile up
	function automatic logic [47:0] insert_time();
		logic [47:0] base;
		int          r;
		base = (sq_count > 0) ? sq_time[0] : 48'd0;
		r = $urandom_range(99);
		if (r < 60)
			return (base > T_MAX - 48'd300) ? base : base + 48'($urandom_range(300));
		else if (r < 75)
			return (base > 48'd50) ? base - 48'($urandom_range(50, 1)) : 48'd0;
		else if (r < 90)
			return rand48();
		else
			return T_MAX - 48'($urandom_range(3));
	endfunction

	// Narrow kinds and jobs most of the time so that lookups see duplicates
	function automatic logic [KIND_BITS-1:0] pick_kind();
		return ($urandom_range(99) < 70) ? KIND_BITS'($urandom_range(3))
		                                 : KIND_BITS'($urandom_range(15));
	endfunction

	function automatic logic [7:0] pick_job();
		return ($urandom_range(99) < 70) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
	endfunction

	task automatic report(string what, logic [47:0] got, logic [47:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	// Offer one item after a random gap, hold it until taken, then predict it
	task automatic offer(logic [FUNC_BITS-1:0] f, logic [47:0] t, logic [KIND_BITS-1:0] k,
			logic [7:0] j, logic [47:0] d, bit typed, head_view_t want);
		int         gap;
		head_view_t pred;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {4'b0, d, j, k, t};
		do
			@(posedge clk);
		while (!s_tready);
		pred = predict_head(f, t, k, j, d);
		pending_views = {pending_views, typed ? want : pred};
	endtask

	task automatic offer_random();
		logic [FUNC_BITS-1:0] f;
		logic [47:0]          t;
		logic [KIND_BITS-1:0] k;
		logic [7:0]           j;
		logic [47:0]          d;
		int                   r;
		int                   idx;
		t = rand48();
		k = pick_kind();
		j = pick_job();
		r = $urandom_range(99);
		if (r < 25)
			d = 48'($urandom_range(300));
		else if (r < 60)
			d = rand48();
		else if (r < 80)
			d = 48'd0;
		else
			d = T_MAX - 48'($urandom_range(7));
		r = $urandom_range(99);
		if (r < 10) begin
			// noise: any command, any fields
			f = FUNC_BITS'($urandom_range(7));
			k = KIND_BITS'($urandom_range(15));
			j = 8'($urandom_range(255));
		end else begin
			r = $urandom_range(99);
			if (r < 45)
				f = FN_INSERT;
			else if (r < 58)
				f = FN_DELAY;
			else if (r < 67)
				f = FN_CANCEL;
			else if (r < 78)
				f = FN_FIND;
			else if (r < 90)
				f = FN_ADVANCE;
			else if (r < 97)
				f = FN_PEEK;
			else if (r < 99)
				f = FN_INIT;
			else
				f = FN_CLEAR;
			if (f == FN_INSERT) begin
				t = insert_time();
			end else if (sq_count > 0 && $urandom_range(99) < 75) begin
				// aim lookups at a live entry
				idx = $urandom_range(sq_count - 1);
				k = sq_kind[idx];
				j = sq_job[idx];
			end
		end
		offer(f, t, k, j, d, 1'b0, '0);
	endtask

	task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [47:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		if (idx == CFG_START_TIME)
			cfg_start = v;
		else
			cfg_end = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drop valid, wait for every pending result, then let the chain settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Fill the queue: a run of inserts, mostly at or past the head
	task automatic insert_burst();
		repeat (36)
			offer(FN_INSERT, insert_time(), pick_kind(), pick_job(), rand48(), 1'b0, '0);
	endtask

	task automatic run_phase(logic [47:0] st, logic [47:0] en, int idle_pct, int stall_pct,
			bit pressure);
		cfg_write(CFG_START_TIME, st);
		cfg_write(CFG_END_TIME, en);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		offer(FN_INIT, rand48(), pick_kind(), pick_job(), rand48(), 1'b0, '0);
		for (int n = 0; n < 220; n++) begin
			if (n % 100 == 40)
				insert_burst();
			// long receiver hold while the sender keeps offering
			if (pressure && n == 60)
				hold_cycles = 400;
			// sender pause until the block has handed back everything
			if (pressure && n == 150)
				drain();
			offer_random();
		end
		drain();
	endtask

	// Receiver: random stalls, or a long hold counted down here
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare every taken result with the oldest pending one, field by field
	always @(posedge clk) begin
		head_view_t got;
		head_view_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(head_view_t)-1:0];
			if (pending_views.size() == 0) begin
				report("result with nothing pending, head_time", got.htime, '0);
			end else begin
				want = pending_views.pop_front();
				if (got.status !== want.status)
					report("status", 48'(got.status), 48'(want.status));
				if (got.hvalid !== want.hvalid)
					report("head_valid", 48'(got.hvalid), 48'(want.hvalid));
				if (got.htime !== want.htime)
					report("head_time", got.htime, want.htime);
				if (got.kind !== want.kind)
					report("head_kind", 48'(got.kind), 48'(want.kind));
				if (got.job !== want.job)
					report("head_job", 48'(got.job), 48'(want.job));
				if (got.found !== want.found)
					report("found_time", got.found, want.found);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = FN_PEEK;
		m_tready       = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_START_TIME;
		cfg_wdata      = '0;
		errors         = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		sq_count       = 0;
		cfg_start      = '0;
		cfg_end        = '0;

		// Directed rows: empty-queue misses, init with reset times, extremes,
		// saturating delay, clear, insert into empty, insert earlier than head
		add_row(FN_PEEK,    '0,    4'd0,  8'd0,   '0,    1'b1,
			mk_view(STAT_MISS, 1'b0, '0, 4'd0, 8'd0, '0));
		add_row(FN_ADVANCE, T_MAX, 4'd15, 8'd255, T_MAX, 1'b1,
			mk_view(STAT_MISS, 1'b0, '0, 4'd0, 8'd0, '0));
		add_row(FN_DELAY,   '0,    4'd2,  8'd3,   48'd10, 1'b1,
			mk_view(STAT_MISS, 1'b0, '0, 4'd0, 8'd0, '0));
		add_row(FN_CANCEL,  '0,    4'd2,  8'd3,   '0,    1'b1,
			mk_view(STAT_MISS, 1'b0, '0, 4'd0, 8'd0, '0));
		add_row(FN_FIND,    '0,    4'd2,  8'd3,   '0,    1'b1,
			mk_view(STAT_MISS, 1'b0, '0, 4'd0, 8'd0, '0));
		add_row(FN_INIT,    '0,    4'd0,  8'd0,   '0,    1'b1,
			mk_view(STAT_OK, 1'b1, '0, KIND_BEGIN, 8'd0, '0));
		add_row(FN_INSERT,  '0,    4'd15, 8'd255, '0,    1'b0, '0);
		add_row(FN_INSERT,  T_MAX, 4'd5,  8'd1,   '0,    1'b0, '0);
		add_row(FN_FIND,    '0,    4'd15, 8'd255, '0,    1'b0, '0);
		add_row(FN_DELAY,   '0,    4'd15, 8'd255, T_MAX, 1'b0, '0);
		add_row(FN_DELAY,   '0,    4'd5,  8'd1,   48'd5, 1'b0, '0);
		add_row(FN_FIND,    '0,    KIND_END, 8'd0, '0,   1'b0, '0);
		add_row(FN_CLEAR,   T_MAX, 4'd15, 8'd255, T_MAX, 1'b1,
			mk_view(STAT_OK, 1'b0, '0, 4'd0, 8'd0, '0));
		add_row(FN_INSERT,  48'd1000, 4'd3, 8'd7, '0,    1'b1,
			mk_view(STAT_OK, 1'b1, 48'd1000, 4'd3, 8'd7, '0));
		add_row(FN_INSERT,  48'd999,  4'd6, 8'd6, '0,    1'b1,
			mk_view(STAT_EARLY, 1'b1, 48'd1000, 4'd3, 8'd7, '0));
		add_row(FN_INSERT,  48'd1000, 4'd4, 8'd8, '0,    1'b0, '0);
		add_row(FN_DELAY,   '0,    4'd3,  8'd7,   '0,    1'b0, '0);
		add_row(FN_CANCEL,  '0,    4'd4,  8'd8,   '0,    1'b0, '0);
		add_row(FN_FIND,    '0,    4'd9,  8'd9,   '0,    1'b0, '0);
		add_row(FN_ADVANCE, '0,    4'd0,  8'd0,   '0,    1'b0, '0);
		add_row(FN_PEEK,    '0,    4'd0,  8'd0,   '0,    1'b0, '0);
		add_row(FN_ADVANCE, '0,    4'd0,  8'd0,   '0,    1'b0, '0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			offer(dir_rows[i].func, dir_rows[i].t, dir_rows[i].kind, dir_rows[i].job,
			      dir_rows[i].dly, dir_rows[i].typed, dir_rows[i].want);
		drain();

		// Settings sweep: end before begin, equal times, random, extremes
		run_phase('0,       '0,       0,  0,  1'b0);
		run_phase(T_MAX,    '0,       74, 0,  1'b0);
		run_phase(rand48(), rand48(), 0,  74, 1'b0);
		run_phase(T_MAX,    T_MAX,    6,  6,  1'b0);
		run_phase(48'd5,    48'd5,    0,  0,  1'b1);
		run_phase('0,       T_MAX,    6,  74, 1'b0);

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/teq_pkg.sv
hw/rtl/teq_cell.sv
hw/rtl/timed_event_queue_core.sv
hw/rtl/teq_checker.sv
test/timed_event_queue_core_tb.sv
